>>> hdl/sfs_pkg.sv
// Shared types and constants of the spring force and strain block.
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [30:0] STIFF_RESET = 31'd65536;

    // One spring after the front end: separation vector and spring data.
    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic        [30:0] leq;
        logic               active;
        logic signed [31:0] prev;
    } t_item;

endpackage

>>> hdl/sfs_front.sv
// Front end: takes a spring, forms the saturated separation vector, feeds the queue.
`timescale 1ns / 1ps

module sfs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic        [30:0] i_rest_length,
    input  logic               i_spring_active,
    input  logic signed [31:0] i_previous_strain,
    output logic               o_push,
    output sfs_pkg::t_item     o_item,
    input  logic               i_full
);
    import sfs_pkg::*;

    function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return d[31:0];
    endfunction

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item.rx     <= sat_diff(i_first_x, i_second_x);
            r_item.ry     <= sat_diff(i_first_y, i_second_y);
            r_item.rz     <= sat_diff(i_first_z, i_second_z);
            r_item.leq    <= i_rest_length;
            r_item.active <= i_spring_active;
            r_item.prev   <= i_previous_strain;
        end
    end

endmodule

>>> hdl/sfs_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps

module sfs_queue #(
    parameter int DEPTH = sfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfs_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output sfs_pkg::t_item o_item,
    input  logic           i_pop
);
    import sfs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

>>> hdl/sfs_div.sv
// Pipelined restoring divider, one quotient bit per stage after the first, quotient capped at 2^31.
`timescale 1ns / 1ps

module sfs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 31
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [31:0]      o_quot
);
    localparam int NSTG = 32;
    localparam int W    = (NUM_W > DEN_W + 31) ? NUM_W : DEN_W + 31;

    logic [W-1:0]     r_rem [NSTG];
    logic [DEN_W-1:0] r_den [NSTG];
    logic [30:0]      r_q   [NSTG];
    logic             r_cap [NSTG];

    // The first stage only checks whether the quotient reaches 2^31.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_cap[0] <= (W'(i_num) >= (W'(i_den) << 31));
        end
    end

    for (genvar s = 1; s < NSTG; s++) begin : g_stage
        localparam int B = NSTG - 1 - s;
        logic [W-1:0] d;
        logic         ge;
        assign d  = W'(r_den[s-1]) << B;
        assign ge = (r_rem[s-1] >= d);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? r_rem[s-1] - d : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= ge ? (r_q[s-1] | (31'd1 << B)) : r_q[s-1];
                r_cap[s] <= r_cap[s-1];
            end
        end
    end

    assign o_quot = r_cap[NSTG-1] ? 32'h8000_0000 : {1'b0, r_q[NSTG-1]};

endmodule

>>> hdl/sfs_back.sv
// Back end: length by pipelined square root, products, divisions and output register.
`timescale 1ns / 1ps

module sfs_back #(
    parameter int FRAC_BITS = sfs_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [30:0]        i_stiffness,
    input  logic               i_q_valid,
    input  sfs_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z,
    output logic signed [31:0] o_strain,
    output logic               o_degenerate
);
    import sfs_pkg::*;

    localparam int NSQ    = 32;
    localparam int NDIV   = 32;
    localparam int NPIPE  = 2 + NSQ + 3 + NDIV;
    localparam int KD_W   = 63;
    localparam int PROD_W = 95;
    localparam int LEQ2_W = 62;
    localparam int DEN_W  = 94;
    localparam int FNUM_W = PROD_W + FRAC_BITS;
    localparam int SNUM_W = 32 + FRAC_BITS;

    typedef struct packed {
        logic [2:0][31:0]   rmag;
        logic [2:0]         rneg;
        logic [30:0]        leq;
        logic               active;
        logic signed [31:0] prev;
    } t_side;

    typedef struct packed {
        logic               active;
        logic               degen;
        logic               dneg;
        logic [2:0]         rneg;
        logic signed [31:0] prev;
    } t_tail;

    // Magnitude is at most 2^31; the positive side saturates to 2^31 - 1.
    function automatic logic [31:0] signed_out(input logic [31:0] mag, input logic neg);
        if (neg) begin
            return 32'd0 - mag;
        end
        return mag[31] ? 32'h7FFF_FFFF : mag;
    endfunction

    logic             en;
    logic [NPIPE-1:0] r_vld;
    logic             r_out_valid;

    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && i_q_valid;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NPIPE-2:0], i_q_valid};
            r_out_valid <= r_vld[NPIPE-1];
        end
    end

    // Squares of the separation components.
    logic [2:0][31:0] w_r;
    t_side            w_side0;
    t_side            r_s1_side;
    logic [63:0]      r_s1_sq [3];

    assign w_r = {i_item.rz, i_item.ry, i_item.rx};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_side0.rneg[i] = w_r[i][31];
            w_side0.rmag[i] = w_r[i][31] ? (~w_r[i] + 32'd1) : w_r[i];
        end
        w_side0.leq    = i_item.leq;
        w_side0.active = i_item.active;
        w_side0.prev   = i_item.prev;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= w_side0;
            for (int i = 0; i < 3; i++) begin
                r_s1_sq[i] <= 64'(w_side0.rmag[i]) * 64'(w_side0.rmag[i]);
            end
        end
    end

    t_side       r_s2_side;
    logic [63:0] r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= r_s1_side;
            r_s2_sum  <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
        end
    end

    // Integer square root, one result bit per stage from the top.
    logic [65:0] r_sq_rem  [NSQ];
    logic [31:0] r_sq_root [NSQ];
    t_side       r_sq_side [NSQ];

    for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
        localparam int J = NSQ - 1 - s;
        logic [65:0] rem_in;
        logic [65:0] trial;
        logic [31:0] root_in;
        t_side       side_in;
        logic        ge;
        if (s == 0) begin : g_first
            assign rem_in  = {2'b00, r_s2_sum};
            assign root_in = '0;
            assign side_in = r_s2_side;
        end else begin : g_next
            assign rem_in  = r_sq_rem[s-1];
            assign root_in = r_sq_root[s-1];
            assign side_in = r_sq_side[s-1];
        end
        assign trial = (66'(root_in) << (J + 1)) | (66'd1 << (2 * J));
        assign ge    = (rem_in >= trial);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[s]  <= ge ? rem_in - trial : rem_in;
                r_sq_root[s] <= ge ? (root_in | (32'd1 << J)) : root_in;
                r_sq_side[s] <= side_in;
            end
        end
    end

    // Elongation, k * |D| and l_eq^2.
    logic [31:0] w_len;
    logic        w_dneg;
    logic [31:0] w_dmag;
    t_side       w_sq_side;

    assign w_len     = r_sq_root[NSQ-1];
    assign w_sq_side = r_sq_side[NSQ-1];
    assign w_dneg    = (w_len < {1'b0, w_sq_side.leq});
    assign w_dmag    = w_dneg ? {1'b0, w_sq_side.leq} - w_len : w_len - {1'b0, w_sq_side.leq};

    t_side             r_a_side;
    logic [31:0]       r_a_len;
    logic [31:0]       r_a_dmag;
    logic              r_a_dneg;
    logic              r_a_degen;
    logic [KD_W-1:0]   r_a_kd;
    logic [LEQ2_W-1:0] r_a_leq2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side  <= w_sq_side;
            r_a_len   <= w_len;
            r_a_dmag  <= w_dmag;
            r_a_dneg  <= w_dneg;
            r_a_degen <= (w_len == '0) || (w_sq_side.leq == '0);
            r_a_kd    <= KD_W'(i_stiffness) * KD_W'(w_dmag);
            r_a_leq2  <= LEQ2_W'(w_sq_side.leq) * LEQ2_W'(w_sq_side.leq);
        end
    end

    // Wide products formed from partial products of the low 32 bits and the upper bits.
    t_side       r_b_side;
    logic [31:0] r_b_dmag;
    logic        r_b_dneg;
    logic        r_b_degen;
    logic [63:0] r_b_flo [3];
    logic [62:0] r_b_fhi [3];
    logic [63:0] r_b_dlo;
    logic [61:0] r_b_dhi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side  <= r_a_side;
            r_b_dmag  <= r_a_dmag;
            r_b_dneg  <= r_a_dneg;
            r_b_degen <= r_a_degen;
            for (int i = 0; i < 3; i++) begin
                r_b_flo[i] <= 64'(r_a_kd[31:0]) * 64'(r_a_side.rmag[i]);
                r_b_fhi[i] <= 63'(r_a_kd[62:32]) * 63'(r_a_side.rmag[i]);
            end
            r_b_dlo <= 64'(r_a_leq2[31:0]) * 64'(r_a_len);
            r_b_dhi <= 62'(r_a_leq2[61:32]) * 62'(r_a_len);
        end
    end

    // Divider operands.
    logic [FNUM_W-1:0] r_c_fnum [3];
    logic [DEN_W-1:0]  r_c_fden;
    logic [SNUM_W-1:0] r_c_snum;
    logic [30:0]       r_c_sden;
    t_tail             r_tail [NDIV + 1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_c_fnum[i] <= FNUM_W'((PROD_W'(r_b_fhi[i]) << 32) + PROD_W'(r_b_flo[i]))
                               << FRAC_BITS;
            end
            r_c_fden         <= (DEN_W'(r_b_dhi) << 32) + DEN_W'(r_b_dlo);
            r_c_snum         <= SNUM_W'(r_b_dmag) << FRAC_BITS;
            r_c_sden         <= r_b_side.leq;
            r_tail[0].active <= r_b_side.active;
            r_tail[0].degen  <= r_b_degen;
            r_tail[0].dneg   <= r_b_dneg;
            r_tail[0].rneg   <= r_b_side.rneg;
            r_tail[0].prev   <= r_b_side.prev;
            for (int k = 1; k <= NDIV; k++) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    logic [31:0] w_fmag [3];
    logic [31:0] w_smag;

    for (genvar i = 0; i < 3; i++) begin : g_fdiv
        sfs_div #(
            .NUM_W (FNUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_c_fnum[i]),
            .i_den  (r_c_fden),
            .o_quot (w_fmag[i])
        );
    end

    sfs_div #(
        .NUM_W (SNUM_W),
        .DEN_W (31)
    ) u_sdiv (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_c_snum),
        .i_den  (r_c_sden),
        .o_quot (w_smag)
    );

    t_tail w_tail;
    assign w_tail = r_tail[NDIV];

    always_ff @(posedge i_clk) begin
        if (en && r_vld[NPIPE-1]) begin
            if (!w_tail.active) begin
                o_force_x    <= '0;
                o_force_y    <= '0;
                o_force_z    <= '0;
                o_strain     <= w_tail.prev;
                o_degenerate <= 1'b0;
            end else if (w_tail.degen) begin
                o_force_x    <= '0;
                o_force_y    <= '0;
                o_force_z    <= '0;
                o_strain     <= '0;
                o_degenerate <= 1'b1;
            end else begin
                o_force_x    <= signed_out(w_fmag[0], w_tail.dneg == w_tail.rneg[0]);
                o_force_y    <= signed_out(w_fmag[1], w_tail.dneg == w_tail.rneg[1]);
                o_force_z    <= signed_out(w_fmag[2], w_tail.dneg == w_tail.rneg[2]);
                o_strain     <= signed_out(w_smag, w_tail.dneg);
                o_degenerate <= 1'b0;
            end
        end
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_force_x == 0 && o_force_y == 0 && o_force_z == 0 && o_strain == 0))
        else $error("degenerate result with nonzero outputs");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[NPIPE-1]))
        else $error("output valid without an item in the last stage");

endmodule

>>> hdl/spring_force_strain.sv
// Top level of the Hookean spring force and strain block.
`timescale 1ns / 1ps
//
// Input channel: one spring per transfer (i_valid high, o_stall low at a clock edge):
// both end positions and previous strain (Q16.16), rest length (unsigned Q15.16), active flag.
// Output channel: one result per transfer (o_valid high, i_stall low): the force on
// the first particle, the strain and the degenerate flag.
// The spring constant is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// do so only while idle, as the block does not enforce it. Throughput is one spring
// per cycle when nothing stalls; a 32-stage square root and four 32-stage dividers
// make up most of the pipeline.
// A stalled output freezes the back pipeline; a short queue keeps taking items until
// it fills, then o_stall rises.
// Synchronous reset clears all valid bits and loads a spring constant of 1.0.
//
module spring_force_strain #(
    parameter int FRAC_BITS   = sfs_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = sfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic        [30:0] i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic        [30:0] i_rest_length,
    input  logic               i_spring_active,
    input  logic signed [31:0] i_previous_strain,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z,
    output logic signed [31:0] o_strain,
    output logic               o_degenerate
);
    import sfs_pkg::*;

    logic [30:0] r_stiffness;
    logic        w_push;
    logic        w_full;
    logic        w_q_valid;
    logic        w_pop;
    t_item       w_front_item;
    t_item       w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= STIFF_RESET;
        end else if (i_cfg_wr_en) begin
            r_stiffness <= i_cfg_wr_data;
        end
    end

    sfs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_first_x         (i_first_x),
        .i_first_y         (i_first_y),
        .i_first_z         (i_first_z),
        .i_second_x        (i_second_x),
        .i_second_y        (i_second_y),
        .i_second_z        (i_second_z),
        .i_rest_length     (i_rest_length),
        .i_spring_active   (i_spring_active),
        .i_previous_strain (i_previous_strain),
        .o_push            (w_push),
        .o_item            (w_front_item),
        .i_full            (w_full)
    );

    sfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    sfs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stiffness  (r_stiffness),
        .i_q_valid    (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_force_x    (o_force_x),
        .o_force_y    (o_force_y),
        .o_force_z    (o_force_z),
        .o_strain     (o_strain),
        .o_degenerate (o_degenerate)
    );

endmodule

>>> tb/spring_force_strain_tb.sv
// Self-checking testbench for the spring force and strain block.
`timescale 1ns / 1ps

module spring_force_strain_tb;

    import sfs_pkg::*;

    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int NUM_PHASES = 4;

    typedef struct {
        logic signed [31:0] fx, fy, fz, sx, sy, sz;
        logic        [30:0] leq;
        logic               active;
        logic signed [31:0] prev;
    } t_spring;

    typedef struct {
        logic signed [31:0] force_x, force_y, force_z, strain;
        logic               degenerate;
    } t_spring_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic        [30:0] i_cfg_wr_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic        [30:0] i_rest_length = '0;
    logic               i_spring_active = 1'b0;
    logic signed [31:0] i_previous_strain = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_force_x, o_force_y, o_force_z, o_strain;
    logic               o_degenerate;

    logic [30:0]    stiffness = STIFF_RESET;
    t_spring_result pending_forces[$];
    int             mismatch_count = 0;
    int             results_checked = 0;
    int             springs_sent = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_cycles = 0;

    spring_force_strain dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_first_x(i_first_x), .i_first_y(i_first_y), .i_first_z(i_first_z),
        .i_second_x(i_second_x), .i_second_y(i_second_y), .i_second_z(i_second_z),
        .i_rest_length(i_rest_length), .i_spring_active(i_spring_active),
        .i_previous_strain(i_previous_strain),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_force_x(o_force_x), .o_force_y(o_force_y), .o_force_z(o_force_z),
        .o_strain(o_strain), .o_degenerate(o_degenerate)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A magnitude of up to 2^31 with a sign, saturated to 32 signed bits.
    function automatic logic signed [31:0] apply_sign(logic [63:0] mag, logic neg);
        if (neg) return -mag[31:0];
        if (mag > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_spring_result hooke_force(t_spring s);
        t_spring_result res;
        longint         sep[3];
        logic [63:0]    mag[3];
        logic [63:0]    sum, len, leq, dmag, smag;
        logic [127:0]   num, den, quot;
        logic           dneg;
        logic signed [31:0] f[3];
        res = '{default: '0};
        if (!s.active) begin
            res.strain = s.prev;
            return res;
        end
        sep[0] = longint'(s.fx) - longint'(s.sx);
        sep[1] = longint'(s.fy) - longint'(s.sy);
        sep[2] = longint'(s.fz) - longint'(s.sz);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (sep[i] > 64'sd2147483647) sep[i] = 64'sd2147483647;
            if (sep[i] < -64'sd2147483648) sep[i] = -64'sd2147483648;
            mag[i] = (sep[i] < 0) ? -sep[i] : sep[i];
            sum = sum + mag[i] * mag[i];
        end
        len = floor_sqrt(sum);
        leq = s.leq;
        if (len == 0 || leq == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        dneg = len < leq;
        dmag = dneg ? leq - len : len - leq;
        smag = (dmag << FRAC) / leq;
        if (smag > 64'h8000_0000) smag = 64'h8000_0000;
        res.strain = apply_sign(smag, dneg);
        den = 128'(leq * leq) * 128'(len);
        for (int i = 0; i < 3; i++) begin
            num = ((128'(stiffness) * 128'(dmag)) * 128'(mag[i])) << FRAC;
            quot = num / den;
            if (quot > 128'h8000_0000) quot = 128'h8000_0000;
            f[i] = apply_sign(quot[63:0], dneg == (sep[i] < 0));
        end
        res.force_x = f[0];
        res.force_y = f[1];
        res.force_z = f[2];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic signed [31:0] got,
                                   logic signed [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_checked, field, got, want);
    endtask

    // Receiver side: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_spring_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_forces.size() == 0) begin
                mismatch_count++;
                $display("UNEXPECTED result at %0t", $realtime);
            end else begin
                want = pending_forces.pop_front();
                if (o_force_x !== want.force_x) report_mismatch("force_x", o_force_x, want.force_x);
                if (o_force_y !== want.force_y) report_mismatch("force_y", o_force_y, want.force_y);
                if (o_force_z !== want.force_z) report_mismatch("force_z", o_force_z, want.force_z);
                if (o_strain !== want.strain) report_mismatch("strain", o_strain, want.strain);
                if (o_degenerate !== want.degenerate)
                    report_mismatch("degenerate", 32'(o_degenerate), 32'(want.degenerate));
            end
            results_checked++;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic offer_spring(t_spring s, logic use_typed, t_spring_result typed);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_first_x = s.fx; i_first_y = s.fy; i_first_z = s.fz;
        i_second_x = s.sx; i_second_y = s.sy; i_second_z = s.sz;
        i_rest_length = s.leq;
        i_spring_active = s.active;
        i_previous_strain = s.prev;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_forces.push_back(use_typed ? typed : hooke_force(s));
        springs_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_set_stiffness(logic [30:0] k);
        i_valid = 1'b0;
        while (pending_forces.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = k;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        stiffness = k;
    endtask

    function automatic t_spring random_spring();
        t_spring s;
        int      kind;
        kind = $urandom_range(99);
        s.fx = $urandom; s.fy = $urandom; s.fz = $urandom;
        s.sx = $urandom; s.sy = $urandom; s.sz = $urandom;
        s.leq = 31'($urandom);
        s.prev = $urandom;
        s.active = 1'b1;
        if (kind < 8) begin
            s.active = 1'b0;
        end else if (kind < 14) begin
            // Coincident particles, or a spring with no rest length.
            if ($urandom_range(1)) begin
                s.sx = s.fx; s.sy = s.fy; s.sz = s.fz;
            end else begin
                s.leq = '0;
            end
        end else if (kind >= 30) begin
            // Realistic springs: nearby particles and a rest length near the span.
            s.fx = $signed(s.fx) >>> $urandom_range(4, 16);
            s.fy = $signed(s.fy) >>> $urandom_range(4, 16);
            s.fz = $signed(s.fz) >>> $urandom_range(4, 16);
            s.sx = s.fx + ($signed(32'($urandom)) >>> $urandom_range(10, 24));
            s.sy = s.fy + ($signed(32'($urandom)) >>> $urandom_range(10, 24));
            s.sz = s.fz + ($signed(32'($urandom)) >>> $urandom_range(10, 24));
            s.leq = 31'($urandom_range(1, 32'h0020_0000) >> $urandom_range(0, 12));
        end
        return s;
    endfunction

    t_spring        spring_rows[$];
    t_spring_result typed_rows[$];
    logic           typed_flag[$];

    task automatic add_row(t_spring s, logic typed, t_spring_result r);
        spring_rows.push_back(s);
        typed_flag.push_back(typed);
        typed_rows.push_back(r);
    endtask

    initial begin
        t_spring        s;
        t_spring_result r;
        logic [30:0]    stiff_steps[NUM_PHASES];
        int             idle_send[NUM_PHASES];
        int             idle_recv[NUM_PHASES];

        stiff_steps = '{31'h7FFF_FFFF, 31'd0, 31'd3 << 15, 31'd0};
        stiff_steps[3] = 31'($urandom);
        idle_send = '{0, 69, 0, 28};
        idle_recv = '{0, 0, 69, 28};

        // Broken spring passes the previous strain through.
        s = '{32'sd5, 32'sd6, 32'sd7, 0, 0, 0, 31'd65536, 1'b0, 32'sh8000_0000};
        r = '{0, 0, 0, 32'sh8000_0000, 1'b0};
        add_row(s, 1'b1, r);
        s.prev = 32'sh7FFF_FFFF; r.strain = 32'sh7FFF_FFFF;
        add_row(s, 1'b1, r);
        // Coincident particles: degenerate.
        s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
              31'h7FFF_FFFF, 1'b1, 32'sd99};
        r = '{0, 0, 0, 0, 1'b1};
        add_row(s, 1'b1, r);
        // Zero rest length: degenerate.
        s = '{32'sd65536, 0, 0, 0, 0, 0, 31'd0, 1'b1, 32'sd1};
        add_row(s, 1'b1, r);
        // Stretched unit spring along x: strain 1.0, force -1.0.
        s = '{32'sd131072, 0, 0, 0, 0, 0, 31'd65536, 1'b1, 0};
        r = '{-32'sd65536, 0, 0, 32'sd65536, 1'b0};
        add_row(s, 1'b1, r);
        // Compressed along y and along z, in opposite directions.
        s = '{0, 32'sd32768, 0, 0, 0, 0, 31'd65536, 1'b1, 0};
        add_row(s, 1'b0, r);
        s = '{0, 0, -32'sd32768, 0, 0, 0, 31'd65536, 1'b1, 0};
        add_row(s, 1'b0, r);
        // Difference saturation at opposite corners of the space.
        s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd1, 1'b1, 0};
        add_row(s, 1'b0, r);
        s.leq = 31'h7FFF_FFFF;
        add_row(s, 1'b0, r);
        // Tiny rest length with a tiny or a huge span, and a tiny span with a huge rest length.
        s = '{32'sd1, 0, 0, 0, 0, 0, 31'd1, 1'b1, 0};
        add_row(s, 1'b0, r);
        s = '{0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 31'd1, 1'b1, 0};
        add_row(s, 1'b0, r);
        s = '{0, 0, 0, 32'sd1, 32'sd1, 32'sd1, 31'h7FFF_FFFF, 1'b1, 0};
        add_row(s, 1'b0, r);
        // Length equal to rest length: zero strain and force.
        s = '{32'sd196608, 32'sd262144, 0, 0, 0, 0, 31'd327680, 1'b1, 0};
        add_row(s, 1'b0, r);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (spring_rows[i]) offer_spring(spring_rows[i], typed_flag[i], typed_rows[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_set_stiffness(stiff_steps[p]);
            send_idle_pct = idle_send[p];
            recv_stall_pct = idle_recv[p];
            // Hold the output off for a long stretch while the sender never idles,
            // so the pipeline and the input queue fill up.
            if (p == 0) hold_cycles = 300;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) offer_spring(random_spring(), 1'b0, r);
        end
        drain_and_set_stiffness(STIFF_RESET);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        repeat (20) offer_spring(random_spring(), 1'b0, r);

        i_valid = 1'b0;
        while (pending_forces.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d springs over %0d stiffness settings and idling mixes.",
                 springs_sent, NUM_PHASES + 2);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
